// File: sv/evm_pkg.sv
// package: payload types, constants and atan table for the view matrix generator
package evm_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
    localparam int FULL_TURN = 23040;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [31:0] POS_Z_RESET = -32'sd131072;
    // ceil(2^43 / 45): floor(angle * 2^32 / 23040) = (angle * ANG_RECIP) >> 20
    localparam logic [37:0] ANG_RECIP = 38'd195468733827;

    typedef struct packed {
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic signed [31:0] move_z;
        logic signed [15:0] turn_x;
        logic signed [15:0] turn_y;
        logic signed [15:0] turn_z;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] elem_0;
        logic signed [31:0] elem_1;
        logic signed [31:0] elem_2;
        logic signed [31:0] elem_3;
        logic               last_row;
    } out_beat_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/evm_cordic.sv
// iterative cordic: sine and cosine of an angle in 1/64 degree, q16.16
module evm_cordic
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [14:0]        angle,
    output logic               done,
    output logic signed [31:0] cos_q16,
    output logic signed [31:0] sin_q16
);

    typedef enum logic [3:0]
    {
        C_IDLE = 4'b0001,
        C_MAP  = 4'b0010,
        C_ITER = 4'b0100,
        C_FIN  = 4'b1000
    } cst_t;

    cst_t state_reg, state_next;
    logic [evm_pkg::STEP_W-1:0] step_reg, step_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [32:0] z_reg, z_next;
    logic flip_reg, flip_next;
    logic [51:0] prod_reg, prod_next;
    logic [31:0] b;
    logic signed [33:0] dx, dy;
    logic signed [33:0] xr, yr;
    logic signed [32:0] at;

    assign b = prod_reg[51:20];
    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;
    assign at = {1'b0, evm_pkg::atan_entry(5'(step_reg))};
    assign xr = (x_reg + 34'sd8192) >>> 14;
    assign yr = (y_reg + 34'sd8192) >>> 14;

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        flip_next = flip_reg;
        prod_next = prod_reg;
        done = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    prod_next = 52'(angle) * 52'(evm_pkg::ANG_RECIP);
                    state_next = C_MAP;
                end
            end
            C_MAP:
            begin
                flip_next = b[31] ^ b[30];
                z_next = 33'(signed'(b + ((b[31] ^ b[30]) ? 32'h80000000 : 32'h0)));
                x_next = evm_pkg::CORDIC_GAIN;
                y_next = '0;
                step_next = '0;
                state_next = C_ITER;
            end
            C_ITER:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == evm_pkg::STEP_W'(evm_pkg::CORDIC_STEPS - 1))
                    state_next = C_FIN;
            end
            C_FIN:
            begin
                done = 1'b1;
                state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    assign cos_q16 = flip_reg ? -xr[31:0] : xr[31:0];
    assign sin_q16 = flip_reg ? -yr[31:0] : yr[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        flip_reg <= flip_next;
        prod_reg <= prod_next;
    end

endmodule

// File: sv/euler_view_matrix_generator.sv
// top level: euler angle camera view matrix generator
//
// in: one beat per camera update (moves in q16.16, turns in 1/64 degree).
// the stored position saturates, the stored angles wrap at 360 degrees.
// out: four beats per update, rows 0..3 of the 4x4 view matrix in q16.16,
// last_row marks row 3. column 3 of rows 0..2 holds the negated position.
// after accept: the update states S_UPD and S_WRAP, then the three
// sine and cosine runs on one shared cordic, then the products on one
// shared multiply-accumulate (two 3x3 products, 9 entries of 3 products and
// one rounding step each), then four output beats.
// in_stall is high from the cycle after accept until the last row beat is taken.
// out_stall holds the current row beat; the block waits for it.
// reset: position 0,0,-2.0, angles zero, no beat pending.
module euler_view_matrix_generator
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  evm_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output evm_pkg::out_beat_t out_data
);

    typedef enum logic [6:0]
    {
        S_IDLE  = 7'b0000001,
        S_UPD   = 7'b0000010,
        S_WRAP  = 7'b0000100,
        S_TRIG  = 7'b0001000,
        S_MAC   = 7'b0010000,
        S_RND   = 7'b0100000,
        S_OUT   = 7'b1000000
    } st_t;

    st_t state_reg, state_next;
    logic signed [31:0] pos_reg [3];
    logic [14:0] ang_reg [3];
    logic signed [17:0] wsum_reg [3];
    logic [1:0] axis_reg;
    logic cstart_reg;
    logic cdone;
    logic signed [31:0] ccos, csin;
    logic signed [31:0] cs_reg [3];
    logic signed [31:0] sn_reg [3];
    logic signed [31:0] t_reg [9];
    logic signed [31:0] m_reg [9];
    logic pass_reg;
    logic [3:0] ent_reg;
    logic [1:0] k_reg;
    logic signed [65:0] acc_reg;
    logic [1:0] row_reg;
    logic signed [31:0] opa, opb;
    logic signed [63:0] prod;
    logic signed [65:0] rnd;
    logic [14:0] ang_sel;

    // matrix elements: pass 0 uses rz*ry, pass 1 uses t*rx
    function automatic logic signed [31:0] rot_elem(input logic [1:0] ax,
        input logic [1:0] r, input logic [1:0] c,
        input logic signed [31:0] co, input logic signed [31:0] si);
        logic signed [31:0] v;
        v = '0;
        case (ax)
            2'd0:
                case ({r, c})
                    4'b0000: v = evm_pkg::ONE_Q16;
                    4'b0101, 4'b1010: v = co;
                    4'b0110: v = -si;
                    4'b1001: v = si;
                    default: v = '0;
                endcase
            2'd1:
                case ({r, c})
                    4'b0101: v = evm_pkg::ONE_Q16;
                    4'b0000, 4'b1010: v = co;
                    4'b0010: v = si;
                    4'b1000: v = -si;
                    default: v = '0;
                endcase
            default:
                case ({r, c})
                    4'b1010: v = evm_pkg::ONE_Q16;
                    4'b0000, 4'b0101: v = co;
                    4'b0001: v = -si;
                    4'b0100: v = si;
                    default: v = '0;
                endcase
        endcase
        return v;
    endfunction

    logic [1:0] ei, ej;
    logic [3:0] tidx;
    assign ei = (ent_reg >= 4'd6) ? 2'd2 : ((ent_reg >= 4'd3) ? 2'd1 : 2'd0);
    assign ej = 2'(ent_reg - 4'(ei) * 4'd3);
    assign tidx = 4'(ei) * 4'd3 + 4'(k_reg);

    always_comb
    begin
        if (!pass_reg)
        begin
            opa = rot_elem(2'd2, ei, k_reg, cs_reg[2], sn_reg[2]);
            opb = rot_elem(2'd1, k_reg, ej, cs_reg[1], sn_reg[1]);
        end
        else
        begin
            opa = t_reg[tidx];
            opb = rot_elem(2'd0, k_reg, ej, cs_reg[0], sn_reg[0]);
        end
    end

    assign prod = opa * opb;
    assign rnd = (acc_reg + 66'sd32768) >>> 16;
    assign ang_sel = (axis_reg == 2'd0) ? ang_reg[0] :
                     ((axis_reg == 2'd1) ? ang_reg[1] : ang_reg[2]);

    evm_cordic u_cordic
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(cstart_reg),
        .angle(ang_sel),
        .done(cdone),
        .cos_q16(ccos),
        .sin_q16(csin)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    logic signed [31:0] negp;
    logic signed [31:0] psel;
    assign psel = (row_reg == 2'd0) ? pos_reg[0] :
                  ((row_reg == 2'd1) ? pos_reg[1] : pos_reg[2]);
    assign negp = (psel == 32'sh80000000) ? 32'sh7FFFFFFF : -psel;

    always_comb
    begin
        out_data.row_index = row_reg;
        out_data.last_row = (row_reg == 2'd3);
        if (row_reg == 2'd3)
        begin
            out_data.elem_0 = '0;
            out_data.elem_1 = '0;
            out_data.elem_2 = '0;
            out_data.elem_3 = evm_pkg::ONE_Q16;
        end
        else
        begin
            out_data.elem_0 = m_reg[4'(row_reg) * 4'd3];
            out_data.elem_1 = m_reg[4'(row_reg) * 4'd3 + 4'd1];
            out_data.elem_2 = m_reg[4'(row_reg) * 4'd3 + 4'd2];
            out_data.elem_3 = negp;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_UPD;
            S_UPD:  state_next = S_WRAP;
            S_WRAP: state_next = S_TRIG;
            S_TRIG: if (cdone && axis_reg == 2'd2) state_next = S_MAC;
            S_MAC:  if (k_reg == 2'd2) state_next = S_RND;
            S_RND:
                if (ent_reg == 4'd8 && pass_reg) state_next = S_OUT;
                else state_next = S_MAC;
            S_OUT:  if (!out_stall && row_reg == 2'd3) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    logic signed [32:0] psum [3];
    evm_pkg::in_beat_t in_hold_reg;

    always_comb
    begin
        psum[0] = 33'(pos_reg[0]) + 33'(in_hold_reg.move_x);
        psum[1] = 33'(pos_reg[1]) + 33'(in_hold_reg.move_y);
        psum[2] = 33'(pos_reg[2]) + 33'(in_hold_reg.move_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            pos_reg[2] <= evm_pkg::POS_Z_RESET;
            ang_reg[0] <= '0;
            ang_reg[1] <= '0;
            ang_reg[2] <= '0;
            axis_reg <= '0;
            cstart_reg <= 1'b0;
            ent_reg <= '0;
            k_reg <= '0;
            pass_reg <= 1'b0;
            row_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cstart_reg <= 1'b0;
            case (state_reg)
                S_UPD:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (psum[i] > 33'sh07FFFFFFF) pos_reg[i] <= 32'sh7FFFFFFF;
                        else if (psum[i] < -33'sh080000000) pos_reg[i] <= 32'sh80000000;
                        else pos_reg[i] <= psum[i][31:0];
                    end
                end
                S_WRAP:
                begin
                    // sum lies in -32768..55806, corrected by at most two full turns
                    for (int i = 0; i < 3; i++)
                    begin
                        if (wsum_reg[i] < -18'sd23040)
                            ang_reg[i] <= 15'(wsum_reg[i] + 18'sd46080);
                        else if (wsum_reg[i] < 0)
                            ang_reg[i] <= 15'(wsum_reg[i] + 18'sd23040);
                        else if (wsum_reg[i] >= 18'sd46080)
                            ang_reg[i] <= 15'(wsum_reg[i] - 18'sd46080);
                        else if (wsum_reg[i] >= 18'sd23040)
                            ang_reg[i] <= 15'(wsum_reg[i] - 18'sd23040);
                        else
                            ang_reg[i] <= 15'(wsum_reg[i]);
                    end
                    axis_reg <= '0;
                    cstart_reg <= 1'b1;
                end
                S_TRIG:
                begin
                    if (cdone)
                    begin
                        if (axis_reg != 2'd2)
                        begin
                            axis_reg <= axis_reg + 2'd1;
                            cstart_reg <= 1'b1;
                        end
                        ent_reg <= '0;
                        k_reg <= '0;
                        pass_reg <= 1'b0;
                    end
                end
                S_MAC: k_reg <= k_reg + 2'd1;
                S_RND:
                begin
                    k_reg <= '0;
                    if (ent_reg == 4'd8)
                    begin
                        ent_reg <= '0;
                        pass_reg <= 1'b1;
                    end
                    else
                        ent_reg <= ent_reg + 4'd1;
                    row_reg <= '0;
                end
                S_OUT: if (!out_stall) row_reg <= row_reg + 2'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            in_hold_reg <= in_data;
        if (state_reg == S_UPD)
        begin
            wsum_reg[0] <= 18'(ang_reg[0]) + 18'(in_hold_reg.turn_x);
            wsum_reg[1] <= 18'(ang_reg[1]) + 18'(in_hold_reg.turn_y);
            wsum_reg[2] <= 18'(ang_reg[2]) + 18'(in_hold_reg.turn_z);
        end
        if (state_reg == S_TRIG && cdone)
        begin
            cs_reg[axis_reg] <= ccos;
            sn_reg[axis_reg] <= csin;
        end
        if (state_reg == S_MAC)
            acc_reg <= ((k_reg == 2'd0) ? 66'sd0 : acc_reg) + 66'(prod);
        if (state_reg == S_RND)
        begin
            if (!pass_reg) t_reg[ent_reg] <= rnd[31:0];
            else m_reg[ent_reg] <= rnd[31:0];
        end
    end

endmodule

// File: verif/tb.sv
// testbench for the euler angle view matrix generator
`timescale 1ns / 100ps

module tb;

    localparam int LIMIT_CYCLES = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    evm_pkg::in_beat_t  in_data;
    logic               out_valid;
    logic               out_stall;
    evm_pkg::out_beat_t out_data;

    euler_view_matrix_generator dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    evm_pkg::out_beat_t rows_due[$];
    int          errors = 0;
    longint      cycles = 0;
    int          stall_left;
    longint      cam_x, cam_y, cam_z;
    int          yaw_x, yaw_y, yaw_z;
    logic [31:0] atan_rom [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic int turn_wrap(int a, longint t);
        longint r;
        r = (longint'(a) + t) % evm_pkg::FULL_TURN;
        if (r < 0)
            r += evm_pkg::FULL_TURN;
        return int'(r);
    endfunction

    task automatic trig_q16(input int ang, output longint c, output longint s);
        logic [31:0] b;
        logic        flip;
        longint      x, y, z, dx, dy;
        b = 32'(({32'(ang), 32'd0}) / 64'd23040);
        flip = (b[31:30] == 2'd1) || (b[31:30] == 2'd2);
        if (flip)
            b = b + 32'h80000000;
        z = longint'($signed(b));
        x = longint'(evm_pkg::CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < evm_pkg::CORDIC_STEPS && i < 24; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(atan_rom[i]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(atan_rom[i]);
            end
        end
        x = floor_shift(x + 8192, 14);
        y = floor_shift(y + 8192, 14);
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endtask

    task automatic predict_view(input evm_pkg::in_beat_t b);
        longint cx, sx, cy, sy, cz, sz, acc;
        longint rx[3][3], ry[3][3], rz[3][3], t[3][3], m[3][3];
        longint negp[3];
        evm_pkg::out_beat_t o;
        cam_x = clamp32(cam_x + longint'(b.move_x));
        cam_y = clamp32(cam_y + longint'(b.move_y));
        cam_z = clamp32(cam_z + longint'(b.move_z));
        yaw_x = turn_wrap(yaw_x, longint'(b.turn_x));
        yaw_y = turn_wrap(yaw_y, longint'(b.turn_y));
        yaw_z = turn_wrap(yaw_z, longint'(b.turn_z));
        trig_q16(yaw_x, cx, sx);
        trig_q16(yaw_y, cy, sy);
        trig_q16(yaw_z, cz, sz);
        rx = '{'{65536, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
        ry = '{'{cy, 0, sy}, '{0, 65536, 0}, '{-sy, 0, cy}};
        rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, 65536}};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += rz[i][k] * ry[k][j];
                t[i][j] = floor_shift(acc + 32768, 16);
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += t[i][k] * rx[k][j];
                m[i][j] = floor_shift(acc + 32768, 16);
            end
        negp[0] = clamp32(-cam_x);
        negp[1] = clamp32(-cam_y);
        negp[2] = clamp32(-cam_z);
        for (int r = 0; r < 3; r++)
        begin
            o.row_index = 2'(r);
            o.elem_0 = 32'(m[r][0]);
            o.elem_1 = 32'(m[r][1]);
            o.elem_2 = 32'(m[r][2]);
            o.elem_3 = 32'(negp[r]);
            o.last_row = 1'b0;
            rows_due.push_back(o);
        end
        o = '0;
        o.row_index = 2'd3;
        o.elem_3 = evm_pkg::ONE_Q16;
        o.last_row = 1'b1;
        rows_due.push_back(o);
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_update(input evm_pkg::in_beat_t b);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_view(b);
    endtask

    function automatic logic signed [31:0] rand_move();
        case ($urandom_range(0, 5))
            0: return 32'(-64'sd2147483648);
            1: return 32'sd2147483647;
            2, 3: return $signed(32'($urandom_range(0, 131072) - 65536));
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_turn();
        if ($urandom_range(0, 9) == 0)
            return $signed(16'($urandom));
        return 16'($signed($urandom_range(0, 46078)) - 23039);
    endfunction

    function automatic evm_pkg::in_beat_t make_update(longint mx, longint my, longint mz,
                                                      int tx, int ty, int tz);
        evm_pkg::in_beat_t b;
        b.move_x = 32'(mx);
        b.move_y = 32'(my);
        b.move_z = 32'(mz);
        b.turn_x = 16'(tx);
        b.turn_y = 16'(ty);
        b.turn_z = 16'(tz);
        return b;
    endfunction

    task automatic test_angles();
        int a[] = '{0, 5760, 11520, 17280, 23039, -23039, 1, -1, 2880, 8640};
        foreach (a[i])
            send_update(make_update(0, 0, 0, a[i], a[(i + 3) % 10], a[(i + 7) % 10]));
    endtask

    task automatic test_saturation();
        send_update(make_update(2147483647, -2147483648, 2147483647, 0, 0, 0));
        send_update(make_update(2147483647, -2147483648, 2147483647, 100, 0, 0));
        send_update(make_update(-2147483648, 2147483647, -2147483648, 0, 0, 0));
        send_update(make_update(-2147483648, 2147483647, -2147483648, 0, 0, 0));
        send_update(make_update(-1, 1, 65536, 0, 0, 0));
        send_update(make_update(-2147483648, -2147483648, -2147483648,
                                -32768, 32767, -32768));
        send_update(make_update(32'h55555555, 32'hAAAAAAAA, 0, 16'h5555, 16'hAAAA, 0));
    endtask

    task automatic test_drain_pause();
        in_valid <= 1'b0;
        while (rows_due.size() != 0)
            @(posedge clk);
        send_update(make_update(65536, 0, 0, 64, 64, 64));
    endtask

    task automatic test_random();
        for (int n = 0; n < 190; n++)
            send_update(make_update(rand_move(), rand_move(), rand_move(),
                                    rand_turn(), rand_turn(), rand_turn()));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left <= gap_len();
        end
    end

    always @(posedge clk)
    begin
        evm_pkg::out_beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rows_due.size() == 0)
            begin
                $error("row beat with nothing expected");
                errors++;
            end
            else
            begin
                e = rows_due.pop_front();
                if (out_data.row_index !== e.row_index)
                begin
                    $error("row_index exp %0d got %0d", e.row_index, out_data.row_index);
                    errors++;
                end
                if (out_data.elem_0 !== e.elem_0)
                begin
                    $error("elem_0 exp %0d got %0d", e.elem_0, out_data.elem_0);
                    errors++;
                end
                if (out_data.elem_1 !== e.elem_1)
                begin
                    $error("elem_1 exp %0d got %0d", e.elem_1, out_data.elem_1);
                    errors++;
                end
                if (out_data.elem_2 !== e.elem_2)
                begin
                    $error("elem_2 exp %0d got %0d", e.elem_2, out_data.elem_2);
                    errors++;
                end
                if (out_data.elem_3 !== e.elem_3)
                begin
                    $error("elem_3 exp %0d got %0d", e.elem_3, out_data.elem_3);
                    errors++;
                end
                if (out_data.last_row !== e.last_row)
                begin
                    $error("last_row exp %0d got %0d", e.last_row, out_data.last_row);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        cam_x = 0;
        cam_y = 0;
        cam_z = -131072;
        yaw_x = 0;
        yaw_y = 0;
        yaw_z = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_angles();
        test_saturation();
        test_drain_pause();
        test_random();
        in_valid <= 1'b0;
        while (rows_due.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
